/* rtl/assert_macros.svh */
// Assertion helpers for the files that check their own logic.
// Both macros expect clk in the enclosing scope, IWPF_ASSERT also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define IWPF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define IWPF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* rtl/iwpf_pkg.sv */
package iwpf_pkg;

    localparam int COUNT_SATURATION = 64;
    localparam int CNT_W            = 7;
    localparam int CFG_W            = 6;
    localparam int CFG_IDX_W        = 3;
    localparam int CHAR_W           = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_LENGTH        = 3'd0,
        REG_MIN_VOWEL_COUNT   = 3'd1,
        REG_MAX_PUNCT_RUN     = 3'd2,
        REG_MAX_REPEAT_RUN    = 3'd3,
        REG_MAX_VOWEL_RUN     = 3'd4,
        REG_MAX_CONSONANT_RUN = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        VC_ACRONYM     = 3'd0,
        VC_OK          = 3'd1,
        VC_SHORT       = 3'd2,
        VC_FEW_VOWELS  = 3'd3,
        VC_PUNCT_RUN   = 3'd4,
        VC_REPEAT_RUN  = 3'd5,
        VC_VOWEL_RUN   = 3'd6,
        VC_CONSON_RUN  = 3'd7
    } verdict_code_t;

    typedef enum logic [1:0] {
        FAIL_PUNCT  = 2'd0,
        FAIL_REPEAT = 2'd1,
        FAIL_VOWEL  = 2'd2,
        FAIL_CONSON = 2'd3
    } fail_kind_t;

    localparam logic [CFG_W-1:0] RST_MIN_LENGTH        = 6'd4;
    localparam logic [CFG_W-1:0] RST_MIN_VOWEL_COUNT   = 6'd1;
    localparam logic [CFG_W-1:0] RST_MAX_PUNCT_RUN     = 6'd1;
    localparam logic [CFG_W-1:0] RST_MAX_REPEAT_RUN    = 6'd2;
    localparam logic [CFG_W-1:0] RST_MAX_VOWEL_RUN     = 6'd4;
    localparam logic [CFG_W-1:0] RST_MAX_CONSONANT_RUN = 6'd5;

    typedef struct packed {
        logic [CFG_W-1:0] min_length;
        logic [CFG_W-1:0] min_vowel_count;
        logic [CFG_W-1:0] max_punct_run;
        logic [CFG_W-1:0] max_repeat_run;
        logic [CFG_W-1:0] max_vowel_run;
        logic [CFG_W-1:0] max_consonant_run;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  length_count;
        logic [CNT_W-1:0]  vowel_total;
        logic              acronym_possible;
        logic [CNT_W-1:0]  punct_run;
        logic [CNT_W-1:0]  repeat_run;
        logic [CNT_W-1:0]  vowel_run;
        logic [CNT_W-1:0]  consonant_run;
        logic [CHAR_W-1:0] previous_letter;
        logic              run_failed;
        fail_kind_t        first_failure_kind;
    } word_state_t;

    typedef struct packed {
        logic          accept;
        verdict_code_t code;
    } verdict_t;

    localparam word_state_t WORD_STATE_CLEAR = '{
        length_count:       '0,
        vowel_total:        '0,
        acronym_possible:   1'b1,
        punct_run:          '0,
        repeat_run:         '0,
        vowel_run:          '0,
        consonant_run:      '0,
        previous_letter:    '0,
        run_failed:         1'b0,
        first_failure_kind: FAIL_PUNCT
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_W'(COUNT_SATURATION)) ? v + CNT_W'(1) : v;
    endfunction

    function automatic logic digit_byte(input logic [CHAR_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic upper_byte(input logic [CHAR_W-1:0] c);
        return c inside {[8'h41:8'h5A]};
    endfunction

    function automatic logic punct_byte(input logic [CHAR_W-1:0] c);
        return c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
    endfunction

    function automatic logic vowel_byte(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] l;
        l = upper_byte(c) ? (c | 8'h20) : c;
        return l inside {8'h61, 8'h65, 8'h69, 8'h6F, 8'h75};
    endfunction

endpackage

/* rtl/iwpf_ifs.sv */
interface iwpf_char_if;
    import iwpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_word;

    modport source (output valid, output char_code, output end_of_word, input ready);
    modport sink   (input valid, input char_code, input end_of_word, output ready);
endinterface

interface iwpf_verdict_if;
    import iwpf_pkg::*;

    logic       valid;
    logic       ready;
    logic       accept;
    logic [2:0] verdict_code;

    modport source (output valid, output accept, output verdict_code, input ready);
    modport sink   (input valid, input accept, input verdict_code, output ready);
endinterface

/* rtl/iwpf_cfg_regs.sv */
module iwpf_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [iwpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iwpf_pkg::CFG_W-1:0]    cfg_data,
    output iwpf_pkg::cfg_t                cfg
);
    import iwpf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LENGTH:        cfg_next.min_length        = cfg_data;
                REG_MIN_VOWEL_COUNT:   cfg_next.min_vowel_count   = cfg_data;
                REG_MAX_PUNCT_RUN:     cfg_next.max_punct_run     = cfg_data;
                REG_MAX_REPEAT_RUN:    cfg_next.max_repeat_run    = cfg_data;
                REG_MAX_VOWEL_RUN:     cfg_next.max_vowel_run     = cfg_data;
                REG_MAX_CONSONANT_RUN: cfg_next.max_consonant_run = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length        <= RST_MIN_LENGTH;
            cfg_reg.min_vowel_count   <= RST_MIN_VOWEL_COUNT;
            cfg_reg.max_punct_run     <= RST_MAX_PUNCT_RUN;
            cfg_reg.max_repeat_run    <= RST_MAX_REPEAT_RUN;
            cfg_reg.max_vowel_run     <= RST_MAX_VOWEL_RUN;
            cfg_reg.max_consonant_run <= RST_MAX_CONSONANT_RUN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/iwpf_word_track.sv */
module iwpf_word_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [iwpf_pkg::CHAR_W-1:0] char_code,
    input  logic                        end_of_word,
    input  iwpf_pkg::cfg_t              cfg,
    output iwpf_pkg::verdict_t          verdict
);
    import iwpf_pkg::*;

    word_state_t st_reg;
    word_state_t st_next;
    word_state_t upd;

    logic c_digit;
    logic c_punct;
    logic c_upper;
    logic c_vowel;
    logic letter_match;

    always_comb
    begin
        c_digit      = digit_byte(char_code);
        c_punct      = punct_byte(char_code);
        c_upper      = upper_byte(char_code);
        c_vowel      = vowel_byte(char_code);
        letter_match = (char_code != '0) && (char_code == st_reg.previous_letter);

        upd = st_reg;
        if ((st_reg.length_count == '0 && !c_upper) || !(c_digit || c_punct || c_upper))
        begin
            upd.acronym_possible = 1'b0;
        end
        upd.length_count = sat_inc(st_reg.length_count);

        if (c_digit)
        begin
            upd.punct_run       = '0;
            upd.repeat_run      = '0;
            upd.vowel_run       = '0;
            upd.consonant_run   = '0;
            upd.previous_letter = '0;
        end
        else if (c_punct)
        begin
            upd.punct_run     = sat_inc(st_reg.punct_run);
            upd.vowel_run     = '0;
            upd.consonant_run = '0;
            if (!upd.run_failed && upd.punct_run > CNT_W'(cfg.max_punct_run))
            begin
                upd.run_failed         = 1'b1;
                upd.first_failure_kind = FAIL_PUNCT;
            end
        end
        else
        begin
            // Repeat check comes first, so it wins over a run failure on the same byte.
            if (letter_match)
            begin
                upd.repeat_run = sat_inc(st_reg.repeat_run);
                if (!upd.run_failed && upd.repeat_run > CNT_W'(cfg.max_repeat_run))
                begin
                    upd.run_failed         = 1'b1;
                    upd.first_failure_kind = FAIL_REPEAT;
                end
            end
            else
            begin
                upd.repeat_run      = '0;
                upd.previous_letter = char_code;
            end

            if (c_vowel)
            begin
                upd.vowel_total   = sat_inc(st_reg.vowel_total);
                upd.vowel_run     = sat_inc(st_reg.vowel_run);
                upd.consonant_run = '0;
                upd.punct_run     = '0;
                if (!upd.run_failed && upd.vowel_run > CNT_W'(cfg.max_vowel_run))
                begin
                    upd.run_failed         = 1'b1;
                    upd.first_failure_kind = FAIL_VOWEL;
                end
            end
            else
            begin
                upd.consonant_run = sat_inc(st_reg.consonant_run);
                upd.vowel_run     = '0;
                upd.punct_run     = '0;
                if (!upd.run_failed && upd.consonant_run > CNT_W'(cfg.max_consonant_run))
                begin
                    upd.run_failed         = 1'b1;
                    upd.first_failure_kind = FAIL_CONSON;
                end
            end
        end
    end

    always_comb
    begin
        if (upd.acronym_possible)
        begin
            verdict.code = VC_ACRONYM;
        end
        else if (upd.length_count < CNT_W'(cfg.min_length))
        begin
            verdict.code = VC_SHORT;
        end
        else if (upd.vowel_total < CNT_W'(cfg.min_vowel_count))
        begin
            verdict.code = VC_FEW_VOWELS;
        end
        else if (upd.run_failed)
        begin
            case (upd.first_failure_kind)
                FAIL_PUNCT:  verdict.code = VC_PUNCT_RUN;
                FAIL_REPEAT: verdict.code = VC_REPEAT_RUN;
                FAIL_VOWEL:  verdict.code = VC_VOWEL_RUN;
                FAIL_CONSON: verdict.code = VC_CONSON_RUN;
                default:     verdict.code = VC_PUNCT_RUN;
            endcase
        end
        else
        begin
            verdict.code = VC_OK;
        end
        verdict.accept = (verdict.code == VC_ACRONYM) || (verdict.code == VC_OK);
    end

    always_comb
    begin
        st_next = st_reg;
        if (fire)
        begin
            st_next = end_of_word ? WORD_STATE_CLEAR : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= WORD_STATE_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

/* rtl/index_word_plausibility_filter.sv */
// Word plausibility filter for a text indexer.
// The chars channel carries one byte of a candidate word per transaction,
// with end_of_word set on the final byte. The verdicts channel carries one
// transaction per word: accept and a 3-bit verdict_code.
// Throughput is one byte per cycle unless the verdict register is stalled;
// the per-byte classification and the counter updates all settle between
// the word state registers and the verdict register. The verdict of a word
// is valid in the cycle after its final byte is accepted.
// A single verdict register sits on the output. While it holds a verdict
// that the receiver has not taken, chars.ready is low; when the receiver
// takes it, a new byte is accepted in the same cycle.
// The configuration port writes cfg_data into register cfg_index at every
// clock edge with cfg_we high; indexes past the last register are ignored.
// Write it only while no word is in progress.
// Reset loads the register defaults, clears the word state and empties the
// verdict register.
`include "assert_macros.svh"

module index_word_plausibility_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [iwpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iwpf_pkg::CFG_W-1:0]     cfg_data,
    iwpf_char_if.sink                      chars,
    iwpf_verdict_if.source                 verdicts
);
    import iwpf_pkg::*;

    cfg_t     cfg;
    verdict_t byte_verdict;
    logic     in_fire;

    logic     out_valid_reg;
    logic     out_valid_next;
    verdict_t out_data_reg;
    verdict_t out_data_next;

    assign chars.ready = !out_valid_reg || verdicts.ready;
    assign in_fire     = chars.valid && chars.ready;

    iwpf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iwpf_word_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .char_code   (chars.char_code),
        .end_of_word (chars.end_of_word),
        .cfg         (cfg),
        .verdict     (byte_verdict)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_fire && chars.end_of_word)
        begin
            out_valid_next = 1'b1;
            out_data_next  = byte_verdict;
        end
        else if (verdicts.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign verdicts.valid        = out_valid_reg;
    assign verdicts.accept       = out_data_reg.accept;
    assign verdicts.verdict_code = out_data_reg.code;

    // A final byte always leaves a verdict behind.
    `IWPF_ASSERT(a_final_byte_gives_verdict, in_fire && chars.end_of_word |=> out_valid_reg)

    // A byte inside a word never produces a verdict on its own.
    `IWPF_ASSERT(a_inner_byte_no_verdict,
        in_fire && !chars.end_of_word && verdicts.ready |=> !out_valid_reg)

    // The accept flag agrees with the verdict code.
    `IWPF_ASSERT(a_accept_matches_code,
        out_valid_reg |-> (out_data_reg.accept ==
            ((out_data_reg.code == VC_ACRONYM) || (out_data_reg.code == VC_OK))))

    // While reset is held the output stays empty.
    `IWPF_ASSERT_ALWAYS(a_reset_empties_output, !rst_n |-> !out_valid_reg)

endmodule

/* tb/tb_top.sv */
module tb_top;
    import iwpf_pkg::*;

    localparam int IDLE_PCT      = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_BYTES   = 120;
    localparam int SETTLE_CYCLES = 4;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

    typedef enum int {BC_DIGIT, BC_UPPER, BC_VOWEL, BC_CONSONANT, BC_PUNCT, BC_ANY} byte_class_t;
    typedef enum int {WK_TEXT, WK_ACRONYM, WK_REPEAT, WK_NOISE, WK_RUN, WK_LONG} word_kind_t;

    typedef struct packed {
        logic          accept;
        verdict_code_t code;
    } verdict_rec_t;

    class word_verdict_board;
        logic [CFG_W-1:0]  min_len, min_vowels, punct_limit;
        logic [CFG_W-1:0]  repeat_limit, vowel_limit, cons_limit;
        logic [CNT_W-1:0]  chars_seen, vowels_seen, punct_len, repeat_len, vowel_len, cons_len;
        logic              acronym_ok, run_bad;
        logic [CHAR_W-1:0] last_letter;
        fail_kind_t        bad_kind;
        verdict_rec_t      verdicts_due[$];
        int                fails;

        function new();
            min_len      = RST_MIN_LENGTH;
            min_vowels   = RST_MIN_VOWEL_COUNT;
            punct_limit  = RST_MAX_PUNCT_RUN;
            repeat_limit = RST_MAX_REPEAT_RUN;
            vowel_limit  = RST_MAX_VOWEL_RUN;
            cons_limit   = RST_MAX_CONSONANT_RUN;
            fails        = 0;
            clear_word();
        endfunction

        function void clear_word();
            chars_seen  = '0;
            vowels_seen = '0;
            acronym_ok  = 1'b1;
            punct_len   = '0;
            repeat_len  = '0;
            vowel_len   = '0;
            cons_len    = '0;
            last_letter = '0;
            run_bad     = 1'b0;
            bad_kind    = FAIL_PUNCT;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v < CNT_W'(COUNT_SATURATION)) ? v + CNT_W'(1) : v;
        endfunction

        function bit is_num(logic [CHAR_W-1:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function bit is_cap(logic [CHAR_W-1:0] c);
            return c >= 8'h41 && c <= 8'h5A;
        endfunction

        function bit is_mark(logic [CHAR_W-1:0] c);
            return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                   (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
        endfunction

        // Only the first run that breaks its limit decides the verdict.
        function void flag(fail_kind_t kind);
            if (!run_bad)
            begin
                run_bad  = 1'b1;
                bad_kind = kind;
            end
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_MIN_LENGTH:        min_len      = v;
                REG_MIN_VOWEL_COUNT:   min_vowels   = v;
                REG_MAX_PUNCT_RUN:     punct_limit  = v;
                REG_MAX_REPEAT_RUN:    repeat_limit = v;
                REG_MAX_VOWEL_RUN:     vowel_limit  = v;
                REG_MAX_CONSONANT_RUN: cons_limit   = v;
                default: ;
            endcase
        endfunction

        function void take_byte(logic [CHAR_W-1:0] c, logic last);
            logic [CHAR_W-1:0] low;
            verdict_rec_t      rec;
            verdict_code_t     code;
            if (chars_seen == 0 && !is_cap(c))
                acronym_ok = 1'b0;
            if (!is_num(c) && !is_mark(c) && !is_cap(c))
                acronym_ok = 1'b0;
            chars_seen = bump(chars_seen);
            if (is_num(c))
            begin
                punct_len   = '0;
                repeat_len  = '0;
                vowel_len   = '0;
                cons_len    = '0;
                last_letter = '0;
            end
            else if (is_mark(c))
            begin
                punct_len = bump(punct_len);
                if (punct_len > punct_limit)
                    flag(FAIL_PUNCT);
                vowel_len = '0;
                cons_len  = '0;
            end
            else
            begin
                // A zero byte never counts as a repeat of the empty last letter.
                if (c != 8'h00 && c == last_letter)
                begin
                    repeat_len = bump(repeat_len);
                    if (repeat_len > repeat_limit)
                        flag(FAIL_REPEAT);
                end
                else
                begin
                    repeat_len  = '0;
                    last_letter = c;
                end
                low = is_cap(c) ? c + 8'h20 : c;
                if (low == 8'h61 || low == 8'h65 || low == 8'h69 || low == 8'h6F ||
                    low == 8'h75)
                begin
                    vowels_seen = bump(vowels_seen);
                    vowel_len   = bump(vowel_len);
                    if (vowel_len > vowel_limit)
                        flag(FAIL_VOWEL);
                    cons_len  = '0;
                    punct_len = '0;
                end
                else
                begin
                    cons_len = bump(cons_len);
                    if (cons_len > cons_limit)
                        flag(FAIL_CONSON);
                    vowel_len = '0;
                    punct_len = '0;
                end
            end
            if (last)
            begin
                if (acronym_ok)
                    code = VC_ACRONYM;
                else if (chars_seen < min_len)
                    code = VC_SHORT;
                else if (vowels_seen < min_vowels)
                    code = VC_FEW_VOWELS;
                else if (run_bad)
                begin
                    case (bad_kind)
                        FAIL_PUNCT:  code = VC_PUNCT_RUN;
                        FAIL_REPEAT: code = VC_REPEAT_RUN;
                        FAIL_VOWEL:  code = VC_VOWEL_RUN;
                        default:     code = VC_CONSON_RUN;
                    endcase
                end
                else
                    code = VC_OK;
                rec.accept = (code == VC_ACRONYM || code == VC_OK);
                rec.code   = code;
                verdicts_due.push_back(rec);
                clear_word();
            end
        endfunction

        task report(string what);
            $display("verdict mismatch: %s", what);
            fails++;
        endtask

        task check_verdict(logic acc, logic [2:0] code);
            verdict_rec_t want;
            if (verdicts_due.size() == 0)
                report($sformatf("verdict accept=%0b code=%0d with no word pending", acc, code));
            else
            begin
                want = verdicts_due.pop_front();
                if (acc !== want.accept)
                    report($sformatf("accept %0b, expected %0b (%s)", acc, want.accept,
                                     want.code.name()));
                if (code !== want.code)
                    report($sformatf("code %0d, expected %0d (%s)", code, want.code,
                                     want.code.name()));
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   calm = 1'b0;
    int                   quiet = 0;
    logic [CHAR_W-1:0]    word_buf[$];
    word_verdict_board    board;

    iwpf_char_if    char_bus();
    iwpf_verdict_if verdict_bus();

    index_word_plausibility_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chars     (char_bus),
        .verdicts  (verdict_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Verdict side: check each transaction, then stall at random.
    always @(posedge clk)
    begin
        if (rst_n && verdict_bus.valid && verdict_bus.ready)
            board.check_verdict(verdict_bus.accept, verdict_bus.verdict_code);
        verdict_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((char_bus.valid && char_bus.ready) || (verdict_bus.valid && verdict_bus.ready))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("[index_word_plausibility_filter] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic byte_class_t rand_class();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return BC_VOWEL;
        else if (r < 75)
            return BC_CONSONANT;
        else if (r < 85)
            return BC_PUNCT;
        else if (r < 92)
            return BC_DIGIT;
        else if (r < 97)
            return BC_UPPER;
        return BC_ANY;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_byte(byte_class_t cls);
        string vowels;
        string consonants;
        vowels     = "aeiouAEIOU";
        consonants = "bcdfghjklmnpqrstvwxyzBCDFGHJKLMNPQRSTVWXYZ";
        case (cls)
            BC_DIGIT:     return 8'($urandom_range(8'h30, 8'h39));
            BC_UPPER:     return 8'($urandom_range(8'h41, 8'h5A));
            BC_VOWEL:     return vowels[$urandom_range(0, vowels.len() - 1)];
            BC_CONSONANT: return consonants[$urandom_range(0, consonants.len() - 1)];
            BC_PUNCT:
            begin
                case ($urandom_range(0, 3))
                    0:       return 8'($urandom_range(8'h21, 8'h2F));
                    1:       return 8'($urandom_range(8'h3A, 8'h40));
                    2:       return 8'($urandom_range(8'h5B, 8'h60));
                    default: return 8'($urandom_range(8'h7B, 8'h7E));
                endcase
            end
            default:      return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void make_word(word_kind_t kind);
        int                len;
        byte_class_t       cls;
        logic [CHAR_W-1:0] b;
        word_buf.delete();
        case (kind)
            WK_TEXT:
            begin
                len = $urandom_range(1, 9);
                repeat (len) word_buf.push_back(pick_byte(rand_class()));
            end
            WK_ACRONYM:
            begin
                word_buf.push_back(pick_byte(($urandom_range(0, 9) == 0) ? rand_class()
                                                                         : BC_UPPER));
                len = $urandom_range(0, 6);
                repeat (len)
                begin
                    case ($urandom_range(0, 9))
                        0, 1:    cls = BC_DIGIT;
                        2:       cls = BC_PUNCT;
                        3:       cls = rand_class();
                        default: cls = BC_UPPER;
                    endcase
                    word_buf.push_back(pick_byte(cls));
                end
            end
            WK_REPEAT:
            begin
                b = pick_byte($urandom_range(0, 1) ? BC_VOWEL : BC_CONSONANT);
                repeat ($urandom_range(0, 2)) word_buf.push_back(pick_byte(rand_class()));
                len = $urandom_range(2, 7);
                // Punctuation inside the run must not break the repeat count.
                for (int i = 0; i < len; i++)
                begin
                    if (i > 0 && $urandom_range(0, 5) == 0)
                        word_buf.push_back(pick_byte(BC_PUNCT));
                    word_buf.push_back(b);
                end
                repeat ($urandom_range(0, 2)) word_buf.push_back(pick_byte(rand_class()));
            end
            WK_NOISE:
                repeat ($urandom_range(1, 10)) word_buf.push_back(pick_byte(BC_ANY));
            WK_RUN:
            begin
                cls = byte_class_t'($urandom_range(BC_DIGIT, BC_PUNCT));
                repeat ($urandom_range(1, 10)) word_buf.push_back(pick_byte(cls));
            end
            default:
            begin
                // Long enough to bring the length count and the run count of its class to or near saturation.
                case ($urandom_range(0, 2))
                    0:       cls = BC_VOWEL;
                    1:       cls = BC_CONSONANT;
                    default: cls = BC_PUNCT;
                endcase
                b   = pick_byte(cls);
                len = $urandom_range(60, 70);
                repeat (len) word_buf.push_back($urandom_range(0, 1) ? b : pick_byte(cls));
            end
        endcase
    endfunction

    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid       <= 1'b1;
        char_bus.char_code   <= c;
        char_bus.end_of_word <= last;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        board.take_byte(c, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Hold off the sender until every verdict has come back.
    task automatic drain();
        char_bus.valid <= 1'b0;
        while (board.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        board.set_limit(idx, v);
    endtask

    task automatic load_limits(input cfg_t v);
        write_reg(REG_MIN_LENGTH, v.min_length);
        write_reg(REG_MIN_VOWEL_COUNT, v.min_vowel_count);
        write_reg(REG_MAX_PUNCT_RUN, v.max_punct_run);
        write_reg(REG_MAX_REPEAT_RUN, v.max_repeat_run);
        write_reg(REG_MAX_VOWEL_RUN, v.max_vowel_run);
        write_reg(REG_MAX_CONSONANT_RUN, v.max_consonant_run);
        write_reg(REG_SPARE_LOW, CFG_W'($urandom));
        write_reg(REG_SPARE_HIGH, CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] rand_limit();
        return ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 63))
                                           : CFG_W'($urandom_range(0, 6));
    endfunction

    task automatic run_phase(input bit allow_long, input bit mid_pause);
        int         sent;
        int         r;
        bit         paused;
        word_kind_t kind;
        sent   = 0;
        paused = 1'b0;
        while (sent < PHASE_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (allow_long && r < 3)
                kind = WK_LONG;
            else if (r < 30)
                kind = WK_TEXT;
            else if (r < 45)
                kind = WK_ACRONYM;
            else if (r < 62)
                kind = WK_REPEAT;
            else if (r < 77)
                kind = WK_NOISE;
            else
                kind = WK_RUN;
            make_word(kind);
            foreach (word_buf[i])
                send_byte(word_buf[i], i == word_buf.size() - 1);
            sent += word_buf.size();
            if (mid_pause && !paused && sent >= PHASE_BYTES / 2)
            begin
                paused = 1'b1;
                drain();
            end
        end
        drain();
    endtask

    initial
    begin
        cfg_t lim;
        board                = new();
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_MIN_LENGTH;
        cfg_data             <= '0;
        char_bus.valid       <= 1'b0;
        char_bus.char_code   <= '0;
        char_bus.end_of_word <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset limits.
        send_text("Z9");
        send_text("ab");
        send_text("abcdfgh");
        send_text("baaaa");
        send_text("ex!!e");
        // Zero bytes must not chain into a repeat; extremes of the byte range.
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h61, 1'b1);
        drain();

        lim = '{RST_MIN_LENGTH, RST_MIN_VOWEL_COUNT, RST_MAX_PUNCT_RUN,
                RST_MAX_REPEAT_RUN, RST_MAX_VOWEL_RUN, RST_MAX_CONSONANT_RUN};
        load_limits(lim);
        run_phase(1'b0, 1'b0);

        lim = '0;
        load_limits(lim);
        run_phase(1'b1, 1'b0);

        lim = '1;
        load_limits(lim);
        run_phase(1'b1, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            lim.min_length        = rand_limit();
            lim.min_vowel_count   = rand_limit();
            lim.max_punct_run     = rand_limit();
            lim.max_repeat_run    = rand_limit();
            lim.max_vowel_run     = rand_limit();
            lim.max_consonant_run = rand_limit();
            load_limits(lim);
            calm = (p == 2);
            run_phase(p == 3, p == 1);
        end
        calm = 1'b0;

        lim = '{6'd1, 6'd0, 6'd0, 6'd1, 6'd1, 6'd2};
        load_limits(lim);
        run_phase(1'b0, 1'b0);

        lim = '{RST_MIN_LENGTH, RST_MIN_VOWEL_COUNT, RST_MAX_PUNCT_RUN,
                RST_MAX_REPEAT_RUN, RST_MAX_VOWEL_RUN, RST_MAX_CONSONANT_RUN};
        load_limits(lim);
        run_phase(1'b0, 1'b0);

        if (board.fails == 0)
            $display("[index_word_plausibility_filter] OK");
        else
            $display("[index_word_plausibility_filter] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/iwpf_pkg.sv
rtl/iwpf_ifs.sv
rtl/iwpf_cfg_regs.sv
rtl/iwpf_word_track.sv
rtl/index_word_plausibility_filter.sv
tb/tb_top.sv
